// File: src/tqes_pkg.sv
package tqes_pkg;

  localparam int unsigned QueuesDefault    = 8;
  localparam int unsigned FifoDepthDefault = 2;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned ProbW   = 16;
  localparam int unsigned UniW    = 16;
  localparam int unsigned EvOutW  = 5;
  localparam int unsigned LenW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;

  localparam logic [LenW-1:0] CapacityReset = 8'd100;
  localparam logic [LenW-1:0] FloorReset    = 8'd0;

  typedef enum logic [CmdW-1:0] {
    CmdLoad  = 2'd0,
    CmdReset = 2'd1,
    CmdStep  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCapacity = 1'b0,
    RegFloor    = 1'b1
  } reg_e;

  // What the back end does with one queued beat.
  typedef enum logic [2:0] {
    KindReport  = 3'd0,
    KindReset   = 3'd1,
    KindArrive  = 3'd2,
    KindDepart  = 3'd3,
    KindTransit = 3'd4
  } kind_e;

endpackage

// File: src/tqes_fifo.sv
module tqes_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tqes_pkg::FifoDepthDefault,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("fifo push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("fifo pop while empty");

endmodule

// File: src/tqes_front.sv
module tqes_front #(
  parameter int unsigned QUEUES = tqes_pkg::QueuesDefault,
  localparam int unsigned TableSize = 3 * QUEUES,
  localparam int unsigned TW        = $clog2(TableSize),
  localparam int unsigned EvW       = $clog2(TableSize + 1),
  localparam int unsigned QW        = $clog2(QUEUES),
  localparam int unsigned KindW     = $bits(tqes_pkg::kind_e),
  localparam int unsigned EntW      = KindW + QW + EvW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tqes_pkg::CmdW-1:0]  command_i,
  input  logic [tqes_pkg::IdxW-1:0]  table_index_i,
  input  logic [tqes_pkg::ProbW-1:0] probability_i,
  input  logic [tqes_pkg::UniW-1:0]  uniform_i,
  output logic                       busy_o,
  output logic                       push_o,
  output logic [EntW-1:0]            entry_o,
  input  logic                       full_i
);

  localparam int unsigned AccW = tqes_pkg::ProbW + $clog2(TableSize);
  localparam logic [EvW-1:0] NoEvent = EvW'(TableSize);

  typedef enum logic [2:0] {
    FIdle = 3'b001,
    FWalk = 3'b010,
    FPush = 3'b100
  } fstate_e;

  fstate_e                    state_q, state_d;
  logic [TW-1:0]              walk_q, walk_d;
  logic [AccW-1:0]            acc_q, acc_d, sum;
  logic [tqes_pkg::UniW-1:0]  u_q, u_d;
  logic [EvW-1:0]             ev_q, ev_d;
  logic [QW-1:0]              k_q, k_d;
  tqes_pkg::kind_e            kind_q, kind_d;

  logic [tqes_pkg::ProbW-1:0] prob_mem [TableSize];
  logic [TableSize-1:0]       tbl_vld_q;
  logic [tqes_pkg::ProbW-1:0] rdata_q, entry;
  logic                       rvld_q;
  logic                       load_we;
  logic [TW-1:0]              load_addr;

  assign load_addr = TW'(table_index_i);
  assign busy_o    = (state_q != FIdle);
  assign push_o    = (state_q == FPush) && !full_i;
  assign entry_o   = {kind_q, k_q, ev_q};

  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    acc_d   = acc_q;
    u_d     = u_q;
    ev_d    = ev_q;
    k_d     = k_q;
    kind_d  = kind_q;
    load_we = 1'b0;
    entry   = rvld_q ? rdata_q : '0;
    sum     = acc_q + AccW'(entry);
    unique case (state_q)
      FIdle: begin
        if (start_i) begin
          ev_d    = NoEvent;
          k_d     = '0;
          kind_d  = tqes_pkg::KindReport;
          state_d = FPush;
          unique case (tqes_pkg::cmd_e'(command_i))
            tqes_pkg::CmdLoad: begin
              load_we = (32'(table_index_i) < TableSize);
            end
            tqes_pkg::CmdReset: begin
              kind_d = tqes_pkg::KindReset;
            end
            tqes_pkg::CmdStep: begin
              u_d     = uniform_i;
              acc_d   = '0;
              walk_d  = '0;
              state_d = FWalk;
            end
            default: ;
          endcase
        end
      end
      FWalk: begin
        if (sum >= AccW'(u_q)) begin
          // classify the hit entry into event kind and queue
          ev_d    = EvW'(walk_q);
          state_d = FPush;
          if (walk_q < TW'(QUEUES)) begin
            kind_d = tqes_pkg::KindArrive;
            k_d    = QW'(walk_q);
          end else if (walk_q < TW'(2 * QUEUES)) begin
            kind_d = tqes_pkg::KindDepart;
            k_d    = QW'(walk_q - TW'(QUEUES));
          end else if (walk_q < TW'(3 * QUEUES - 1)) begin
            kind_d = tqes_pkg::KindTransit;
            k_d    = QW'(walk_q - TW'(2 * QUEUES));
          end else begin
            kind_d = tqes_pkg::KindDepart;
            k_d    = QW'(QUEUES - 1);
          end
        end else if (walk_q == TW'(TableSize - 1)) begin
          ev_d    = NoEvent;
          kind_d  = tqes_pkg::KindReport;
          state_d = FPush;
        end else begin
          walk_d = walk_q + TW'(1);
          acc_d  = sum;
        end
      end
      FPush: begin
        if (!full_i) begin
          state_d = FIdle;
        end
      end
      default: state_d = FIdle;
    endcase
  end

  // table memory: read address is always the next entry of the walk
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      prob_mem[load_addr] <= probability_i;
    end
    rdata_q <= prob_mem[walk_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FIdle;
      tbl_vld_q <= '0;
      rvld_q    <= 1'b0;
      walk_q    <= '0;
      acc_q     <= '0;
      kind_q    <= tqes_pkg::KindReport;
    end else begin
      state_q <= state_d;
      if (load_we) begin
        tbl_vld_q[load_addr] <= 1'b1;
      end
      rvld_q <= tbl_vld_q[walk_d];
      walk_q <= walk_d;
      acc_q  <= acc_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    ev_q <= ev_d;
    k_q  <= k_d;
  end

  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FWalk) |-> (walk_q <= TW'(TableSize - 1)))
    else $error("table walk ran past the last entry");

endmodule

// File: src/tqes_back.sv
module tqes_back #(
  parameter int unsigned QUEUES = tqes_pkg::QueuesDefault,
  localparam int unsigned TableSize = 3 * QUEUES,
  localparam int unsigned EvW       = $clog2(TableSize + 1),
  localparam int unsigned QW        = $clog2(QUEUES),
  localparam int unsigned KindW     = $bits(tqes_pkg::kind_e),
  localparam int unsigned EntW      = KindW + QW + EvW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tqes_pkg::LenW-1:0]   capacity_i,
  input  logic [tqes_pkg::LenW-1:0]   floor_i,
  input  logic                        empty_i,
  input  logic [EntW-1:0]             entry_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic [tqes_pkg::EvOutW-1:0] event_index_o,
  output logic                        coupled_o
);

  localparam int unsigned LenW = tqes_pkg::LenW;
  localparam int unsigned MW   = $clog2(QUEUES + 1);

  typedef enum logic [2:0] {
    BIdle = 3'b001,
    BCalc = 3'b010,
    BWr2  = 3'b100
  } bstate_e;

  bstate_e          state_q, state_d;
  tqes_pkg::kind_e  head_kind, kind_q, kind_d;
  logic [QW-1:0]    head_k, k_q, k_d, k1, rd_a, rd_b, wr_addr;
  logic [EvW-1:0]   head_ev, ev_q, ev_d;

  logic [LenW-1:0]  lower_mem [QUEUES];
  logic [LenW-1:0]  upper_mem [QUEUES];
  logic [LenW-1:0]  lo_a_q, lo_b_q, up_a_q, up_b_q;
  logic             fa_q, fb_q;
  logic [QUEUES-1:0] fresh_q, fresh_d;
  logic [LenW-1:0]  lo_init_q, lo_init_d, up_init_q, up_init_d;
  logic [MW-1:0]    mism_q, mism_d, mism_step;

  logic [LenW-1:0]  lo_k, lo_k1, up_k, up_k1;
  logic [LenW-1:0]  nlo_k, nlo_k1, nup_k, nup_k1;
  logic [LenW-1:0]  hold_lo_q, hold_lo_d, hold_up_q, hold_up_d;
  logic [LenW-1:0]  wr_lo, wr_up;
  logic             wr_en, transit;
  logic             omk, omk1, nmk, nmk1;

  logic             res_vld_q, res_vld_d, res_cpl_q, res_cpl_d;
  logic [EvW-1:0]   res_ev_q, res_ev_d;
  logic [EvW+tqes_pkg::EvOutW-1:0] ev_wide;

  // next lengths of queue k and k+1 for one trajectory
  function automatic logic [2*LenW-1:0] traj_next(tqes_pkg::kind_e kind,
                                                  logic [LenW-1:0] qk,
                                                  logic [LenW-1:0] qk1,
                                                  logic [LenW-1:0] cap,
                                                  logic [LenW-1:0] flr);
    logic [LenW-1:0] nk;
    logic [LenW-1:0] nk1;
    nk  = qk;
    nk1 = qk1;
    case (kind)
      tqes_pkg::KindArrive: begin
        if (qk < cap) nk = qk + LenW'(1);
      end
      tqes_pkg::KindDepart: begin
        if (qk > flr) nk = qk - LenW'(1);
      end
      tqes_pkg::KindTransit: begin
        if (qk > flr) begin
          nk = qk - LenW'(1);
          if (qk1 < cap) nk1 = qk1 + LenW'(1);
        end
      end
      default: ;
    endcase
    return {nk, nk1};
  endfunction

  assign head_kind = tqes_pkg::kind_e'(entry_i[EntW-1 -: KindW]);
  assign head_k    = entry_i[EvW +: QW];
  assign head_ev   = entry_i[EvW-1:0];

  assign pop_o = (state_q == BIdle) && !empty_i;
  assign rd_a  = head_k;
  assign rd_b  = (head_kind == tqes_pkg::KindTransit) ? head_k + QW'(1) : head_k;
  assign k1    = k_q + QW'(1);

  // untouched entries since the last trajectory reset read as the reset value
  assign lo_k  = fa_q ? lo_init_q : lo_a_q;
  assign up_k  = fa_q ? up_init_q : up_a_q;
  assign lo_k1 = fb_q ? lo_init_q : lo_b_q;
  assign up_k1 = fb_q ? up_init_q : up_b_q;

  assign {nlo_k, nlo_k1} = traj_next(kind_q, lo_k, lo_k1, capacity_i, floor_i);
  assign {nup_k, nup_k1} = traj_next(kind_q, up_k, up_k1, capacity_i, floor_i);

  assign transit   = (kind_q == tqes_pkg::KindTransit);
  assign omk       = (lo_k != up_k);
  assign nmk       = (nlo_k != nup_k);
  assign omk1      = transit && (lo_k1 != up_k1);
  assign nmk1      = transit && (nlo_k1 != nup_k1);
  assign mism_step = mism_q + MW'(nmk) + MW'(nmk1) - MW'(omk) - MW'(omk1);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    k_d       = k_q;
    ev_d      = ev_q;
    fresh_d   = fresh_q;
    lo_init_d = lo_init_q;
    up_init_d = up_init_q;
    mism_d    = mism_q;
    hold_lo_d = hold_lo_q;
    hold_up_d = hold_up_q;
    res_vld_d = 1'b0;
    res_ev_d  = res_ev_q;
    res_cpl_d = res_cpl_q;
    wr_en     = 1'b0;
    wr_addr   = k_q;
    wr_lo     = nlo_k;
    wr_up     = nup_k;
    unique case (state_q)
      BIdle: begin
        if (!empty_i) begin
          kind_d = head_kind;
          k_d    = head_k;
          ev_d   = head_ev;
          unique case (head_kind) inside
            tqes_pkg::KindReset: begin
              lo_init_d = floor_i;
              up_init_d = capacity_i;
              fresh_d   = '1;
              mism_d    = (floor_i == capacity_i) ? '0 : MW'(QUEUES);
              res_vld_d = 1'b1;
              res_ev_d  = head_ev;
              res_cpl_d = (floor_i == capacity_i);
            end
            tqes_pkg::KindArrive, tqes_pkg::KindDepart, tqes_pkg::KindTransit: begin
              state_d = BCalc;
            end
            default: begin
              res_vld_d = 1'b1;
              res_ev_d  = head_ev;
              res_cpl_d = (mism_q == '0);
            end
          endcase
        end
      end
      BCalc: begin
        wr_en         = 1'b1;
        fresh_d[k_q]  = 1'b0;
        mism_d        = mism_step;
        hold_lo_d     = nlo_k1;
        hold_up_d     = nup_k1;
        if (transit) begin
          state_d = BWr2;
        end else begin
          state_d   = BIdle;
          res_vld_d = 1'b1;
          res_ev_d  = ev_q;
          res_cpl_d = (mism_step == '0);
        end
      end
      BWr2: begin
        // write the downstream queue of a transit
        wr_en       = 1'b1;
        wr_addr     = k1;
        wr_lo       = hold_lo_q;
        wr_up       = hold_up_q;
        fresh_d[k1] = 1'b0;
        state_d     = BIdle;
        res_vld_d   = 1'b1;
        res_ev_d    = ev_q;
        res_cpl_d   = (mism_q == '0);
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lower_mem[wr_addr] <= wr_lo;
      upper_mem[wr_addr] <= wr_up;
    end
    lo_a_q <= lower_mem[rd_a];
    lo_b_q <= lower_mem[rd_b];
    up_a_q <= upper_mem[rd_a];
    up_b_q <= upper_mem[rd_b];
    fa_q   <= fresh_q[rd_a];
    fb_q   <= fresh_q[rd_b];
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    ev_q      <= ev_d;
    hold_lo_q <= hold_lo_d;
    hold_up_q <= hold_up_d;
    res_ev_q  <= res_ev_d;
    res_cpl_q <= res_cpl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BIdle;
      kind_q    <= tqes_pkg::KindReport;
      fresh_q   <= '1;
      lo_init_q <= '0;
      up_init_q <= '0;
      mism_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      fresh_q   <= fresh_d;
      lo_init_q <= lo_init_d;
      up_init_q <= up_init_d;
      mism_q    <= mism_d;
      res_vld_q <= res_vld_d;
    end
  end

  assign ev_wide       = (EvW + tqes_pkg::EvOutW)'(res_ev_q);
  assign event_index_o = ev_wide[tqes_pkg::EvOutW-1:0];
  assign done_o        = res_vld_q;
  assign coupled_o     = res_cpl_q;

  a_mism_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mism_q <= MW'(QUEUES))
    else $error("mismatch count above queue count");

  a_coupled_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_cpl_q) |-> (mism_q == '0))
    else $error("coupled reported with mismatching queues");

  a_wr2_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BWr2) |-> ($past(state_q == BCalc) && transit))
    else $error("second write without a transit calc");

endmodule

// File: src/tandem_queue_event_sampler.sv
// Channel   Dir  Beat taken when          Fields
// command   in   start_i && !busy_o       command_i, table_index_i, probability_i, uniform_i
// result    out  done_o (one cycle only)  event_index_o, coupled_o
// config    in   cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A load, a trajectory reset or an unused command holds busy_o only for the hand-off.
// A step holds busy_o while it walks n = 1 to 3*QUEUES table entries and for the hand-off:
// the walk takes one probability a cycle from the table memory.
// The back end applies the event behind a FIFO_DEPTH queue;
// a full queue holds the front end in its hand-off cycle.
// After reset the block takes a command at once; there is no clearing pass.
module tandem_queue_event_sampler #(
  parameter int unsigned QUEUES     = tqes_pkg::QueuesDefault,
  parameter int unsigned FIFO_DEPTH = tqes_pkg::FifoDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [tqes_pkg::CmdW-1:0]    command_i,
  input  logic [tqes_pkg::IdxW-1:0]    table_index_i,
  input  logic [tqes_pkg::ProbW-1:0]   probability_i,
  input  logic [tqes_pkg::UniW-1:0]    uniform_i,
  output logic                         done_o,
  output logic [tqes_pkg::EvOutW-1:0]  event_index_o,
  output logic                         coupled_o,
  input  logic                         cfg_we_i,
  input  logic [tqes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tqes_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned TableSize = 3 * QUEUES;
  localparam int unsigned EvW       = $clog2(TableSize + 1);
  localparam int unsigned QW        = $clog2(QUEUES);
  localparam int unsigned EntW      = $bits(tqes_pkg::kind_e) + QW + EvW;

  logic [tqes_pkg::LenW-1:0] capacity_q, floor_q;
  logic                      push, full, pop, empty;
  logic [EntW-1:0]           push_data, head_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= tqes_pkg::CapacityReset;
      floor_q    <= tqes_pkg::FloorReset;
    end else if (cfg_we_i) begin
      unique case (tqes_pkg::reg_e'(cfg_idx_i))
        tqes_pkg::RegCapacity: capacity_q <= cfg_wdata_i;
        tqes_pkg::RegFloor:    floor_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tqes_front #(
    .QUEUES(QUEUES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .command_i     (command_i),
    .table_index_i (table_index_i),
    .probability_i (probability_i),
    .uniform_i     (uniform_i),
    .busy_o        (busy_o),
    .push_o        (push),
    .entry_o       (push_data),
    .full_i        (full)
  );

  tqes_fifo #(
    .WIDTH(EntW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (empty)
  );

  tqes_back #(
    .QUEUES(QUEUES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_i    (capacity_q),
    .floor_i       (floor_q),
    .empty_i       (empty),
    .entry_i       (head_data),
    .pop_o         (pop),
    .done_o        (done_o),
    .event_index_o (event_index_o),
    .coupled_o     (coupled_o)
  );

endmodule
